// ===== rtl/ledgs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ledgs_pkg
// Shared constants and codes of the LED driver grayscale serialiser.
// ----------------------------------------------------------------------------
package ledgs_pkg;

	localparam int CHANNELS = 48;
	localparam int CH_W     = $clog2(CHANNELS);
	localparam int GS_W     = 12;
	localparam int DC_W     = 6;

	localparam logic [GS_W-1:0] GS_MAX = {GS_W{1'b1}};
	localparam logic [DC_W-1:0] DC_MAX = {DC_W{1'b1}};

	typedef enum logic [2:0] {
		MODE_WR_GS  = 3'd0,
		MODE_WR_DC  = 3'd1,
		MODE_UPDATE = 3'd2,
		MODE_INIT   = 3'd3,
		MODE_TICK   = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		ACT_BLANK_HI = 3'd0,
		ACT_PROG_LO  = 3'd1,
		ACT_LATCH    = 3'd2,
		ACT_XCLK     = 3'd3,
		ACT_BLANK_LO = 3'd4,
		ACT_GS_WORD  = 3'd5,
		ACT_DC_WORD  = 3'd6
	} action_t;

endpackage

`default_nettype wire

// ===== rtl/led_driver_grayscale_serializer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// led_driver_grayscale_serializer
// Host-side loader for a chain of grayscale LED drivers.
//
// Commands arrive on the s_ channel: tuser carries the mode, tdata the channel
// and value. Brightness/correction writes and update requests give no result.
// Init and refresh tick emit a run of actions on the m_ channel, tuser the
// action, tdata the word and its channel, tlast on the final transfer of the
// run.
// Words come from two single-port synchronous memories through a read stage,
// so words stream one transfer per cycle while the receiver takes them: init
// gives CHANNELS + 2 transfers, a tick 2 to 5 plus CHANNELS when data is
// pending. A command is taken only once the previous run has been issued; a
// tick then starts in the fixed-action state, an init in the read stage.
// A stall on m_tready holds the output register and the memory read stage.
// Reset clears the flags and the per-entry valid bits, so brightness reads as
// zero and correction as full scale until written; no clearing pass is needed.
// ----------------------------------------------------------------------------
module led_driver_grayscale_serializer
	import ledgs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [23:0] s_tdata,  // [7:0] channel, [23:8] value
	input  wire logic [2:0]  s_tuser,  // [2:0] mode
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [23:0] m_tdata,  // [11:0] word, [17:12] word_channel, [23:18] zero
	output      logic [2:0]  m_tuser,  // [2:0] action
	output      logic        m_tlast
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_FIX  = 3'b010,
		ST_WORD = 3'b100
	} state_t;

	state_t            state_q;
	logic [4:0]        mask_q;
	logic              words_after_q;
	logic              fix_after_q;
	logic              sel_dc_q;
	logic              data_pend_q;
	logic              latch_pend_q;
	logic              prog_q;
	logic [CH_W-1:0]   rd_idx_q;
	logic              rd_done_q;
	logic              rd_s1;
	logic [CH_W-1:0]   idx_s1;
	logic [GS_W-1:0]   gs_s1;
	logic [DC_W-1:0]   dc_s1;
	logic              gs_ok_s1;
	logic              dc_ok_s1;
	logic [CHANNELS-1:0] gs_vld_q;
	logic [CHANNELS-1:0] dc_vld_q;
	logic [GS_W-1:0]   gs_mem [CHANNELS];
	logic [DC_W-1:0]   dc_mem [CHANNELS];

	logic              out_vld_q;
	logic [2:0]        out_act_q;
	logic [GS_W-1:0]   out_word_q;
	logic [CH_W-1:0]   out_ch_q;
	logic              out_last_q;

	logic              accept;
	mode_t             mode;
	logic [7:0]        ch_in;
	logic [15:0]       val_in;
	logic              ch_ok;
	logic [CH_W-1:0]   ch_idx;
	logic [GS_W-1:0]   gs_sat;
	logic [DC_W-1:0]   dc_sat;
	logic              out_free;
	logic              rd_en;
	logic [2:0]        fix_act;
	logic [4:0]        mask_nxt;
	logic              load_fix;
	logic              load_word;
	logic [GS_W-1:0]   word_val;

	assign mode     = mode_t'(s_tuser);
	assign ch_in    = s_tdata[7:0];
	assign val_in   = s_tdata[23:8];
	assign ch_ok    = ch_in < 8'(CHANNELS);
	assign ch_idx   = ch_in[CH_W-1:0];
	assign gs_sat   = (val_in > 16'(GS_MAX)) ? GS_MAX : val_in[GS_W-1:0];
	assign dc_sat   = (val_in > 16'(DC_MAX)) ? DC_MAX : val_in[DC_W-1:0];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_vld_q || m_tready;

	// lowest pending fixed action; codes run in emission order
	always_comb begin
		priority if (mask_q[0]) fix_act = ACT_BLANK_HI;
		else if (mask_q[1])     fix_act = ACT_PROG_LO;
		else if (mask_q[2])     fix_act = ACT_LATCH;
		else if (mask_q[3])     fix_act = ACT_XCLK;
		else                    fix_act = ACT_BLANK_LO;
	end
	assign mask_nxt  = mask_q & (mask_q - 5'd1);
	assign load_fix  = (state_q == ST_FIX) && out_free;
	assign load_word = (state_q == ST_WORD) && rd_s1 && out_free;
	assign rd_en     = (state_q == ST_WORD) && !rd_done_q && (!rd_s1 || out_free);

	always_comb begin
		if (sel_dc_q) begin
			word_val = dc_ok_s1 ? {{(GS_W-DC_W){1'b0}}, dc_s1} : {{(GS_W-DC_W){1'b0}}, DC_MAX};
		end else begin
			word_val = gs_ok_s1 ? gs_s1 : '0;
		end
	end

	// store writes and the read stage
	always_ff @(posedge clk) begin
		if (accept && ch_ok && mode == MODE_WR_GS) begin
			gs_mem[ch_idx] <= gs_sat;
		end
		if (accept && ch_ok && mode == MODE_WR_DC) begin
			dc_mem[ch_idx] <= dc_sat;
		end
		if (rd_en) begin
			gs_s1    <= gs_mem[rd_idx_q];
			dc_s1    <= dc_mem[rd_idx_q];
			gs_ok_s1 <= gs_vld_q[rd_idx_q];
			dc_ok_s1 <= dc_vld_q[rd_idx_q];
			idx_s1   <= rd_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gs_vld_q <= '0;
			dc_vld_q <= '0;
		end else if (accept && ch_ok) begin
			if (mode == MODE_WR_GS) gs_vld_q[ch_idx] <= 1'b1;
			if (mode == MODE_WR_DC) dc_vld_q[ch_idx] <= 1'b1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			mask_q        <= '0;
			words_after_q <= 1'b0;
			fix_after_q   <= 1'b0;
			sel_dc_q      <= 1'b0;
			data_pend_q   <= 1'b0;
			latch_pend_q  <= 1'b0;
			prog_q        <= 1'b0;
			rd_idx_q      <= '0;
			rd_done_q     <= 1'b0;
			rd_s1         <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_idx_q  <= rd_idx_q - CH_W'(1);
				rd_done_q <= (rd_idx_q == '0);
			end
			if (rd_en) begin
				rd_s1 <= 1'b1;
			end else if (out_free) begin
				rd_s1 <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (mode)
							MODE_UPDATE: data_pend_q <= 1'b1;
							MODE_INIT: begin
								prog_q        <= 1'b1;
								sel_dc_q      <= 1'b1;
								mask_q        <= 5'b10100;
								fix_after_q   <= 1'b1;
								words_after_q <= 1'b0;
								rd_idx_q      <= CH_W'(CHANNELS - 1);
								rd_done_q     <= 1'b0;
								state_q       <= ST_WORD;
							end
							MODE_TICK: begin
								prog_q        <= 1'b0;
								latch_pend_q  <= data_pend_q;
								data_pend_q   <= 1'b0;
								sel_dc_q      <= 1'b0;
								mask_q        <= {1'b1, prog_q, latch_pend_q, prog_q, 1'b1};
								fix_after_q   <= 1'b0;
								words_after_q <= data_pend_q;
								state_q       <= ST_FIX;
							end
							default: ;
						endcase
					end
				end
				ST_FIX: begin
					if (load_fix) begin
						mask_q <= mask_nxt;
						if (mask_nxt == '0) begin
							if (words_after_q) begin
								rd_idx_q  <= CH_W'(CHANNELS - 1);
								rd_done_q <= 1'b0;
								state_q   <= ST_WORD;
							end else begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				ST_WORD: begin
					if (load_word && idx_s1 == '0) begin
						state_q <= fix_after_q ? ST_FIX : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_fix || load_word) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_fix) begin
			out_act_q  <= fix_act;
			out_word_q <= '0;
			out_ch_q   <= '0;
			out_last_q <= (mask_nxt == '0) && !words_after_q;
		end else if (load_word) begin
			out_act_q  <= sel_dc_q ? ACT_DC_WORD : ACT_GS_WORD;
			out_word_q <= word_val;
			out_ch_q   <= idx_s1;
			out_last_q <= (idx_s1 == '0) && !fix_after_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_act_q;
	assign m_tdata  = {{(24-GS_W-CH_W){1'b0}}, out_ch_q, out_word_q};
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/ledgs_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ledgs_checker
// Port-level checks on the result channel of the serialiser.
// ----------------------------------------------------------------------------
module ledgs_checker
	import ledgs_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata,
	input wire logic [2:0]  m_tuser
);

	// a stalled transfer stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// control actions carry no word and no channel
	a_ctrl_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ACT_GS_WORD && m_tuser != ACT_DC_WORD |-> m_tdata == '0)
		else $error("control action with non-zero data");

	// correction words fit their width
	a_dc_width: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ACT_DC_WORD |-> m_tdata[GS_W-1:DC_W] == '0)
		else $error("correction word too wide");

	// word channels stay in range
	a_ch_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ACT_GS_WORD || m_tuser == ACT_DC_WORD)
		|-> m_tdata[GS_W+CH_W-1:GS_W] < CH_W'(CHANNELS))
		else $error("word channel out of range");

endmodule

bind led_driver_grayscale_serializer ledgs_checker u_ledgs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

// ===== sim/led_driver_grayscale_serializer_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// led_driver_grayscale_serializer_tb
// Self-checking bench for the grayscale/correction loader of the LED drivers.
//
// Commands go in on the s_ stream and a built-in predictor keeps its own copy
// of both word stores and the three flags. Every transfer on the m_ stream is
// checked field by field against the oldest predicted action. Directed tests
// cover reset contents, saturation, ignored channels and modes, repeated init
// and the program/latch sequence of a tick. A long receiver hold-off fills
// the block. Random frames of writes, updates and ticks then run under three
// patterns of idling on both sides.
// ----------------------------------------------------------------------------
module led_driver_grayscale_serializer_tb;
	import ledgs_pkg::*;

	localparam int HOLD_CYCLES = 400;
	localparam int WDOG_LIMIT  = 4000;
	localparam int TAIL_CYCLES = 20;

	typedef struct packed {
		logic [2:0]  action;
		logic [11:0] word;
		logic [5:0]  chan;
		logic        last;
	} beat_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;
	logic [2:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	// predictor state
	logic [GS_W-1:0] gs_mem [CHANNELS];
	logic [DC_W-1:0] dc_mem [CHANNELS];
	bit              data_due;
	bit              latch_due;
	bit              prog_on;
	beat_t           due_actions [$];

	int errors    = 0;
	int snd_idle  = 0;
	int rcv_idle  = 0;
	int hold_req  = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cnt = 0;
	beat_t seen, want;

	led_driver_grayscale_serializer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void push_act(action_t a, logic [11:0] w, logic [5:0] c);
		beat_t b;
		b.action = a;
		b.word   = w;
		b.chan   = c;
		b.last   = 1'b0;
		due_actions.push_back(b);
	endfunction

	// Work out the actions one accepted command causes and update the stores.
	function automatic void apply_command(logic [2:0] mode, logic [7:0] ch, logic [15:0] val);
		int    n0;
		bit    first;
		beat_t b;
		n0    = due_actions.size();
		first = 1'b0;
		case (mode)
			MODE_WR_GS: begin
				if (ch < CHANNELS)
					gs_mem[ch[CH_W-1:0]] = (val > GS_MAX) ? GS_MAX : val[GS_W-1:0];
			end
			MODE_WR_DC: begin
				if (ch < CHANNELS)
					dc_mem[ch[CH_W-1:0]] = (val > DC_MAX) ? DC_MAX : val[DC_W-1:0];
			end
			MODE_UPDATE: data_due = 1'b1;
			MODE_INIT: begin
				for (int i = CHANNELS - 1; i >= 0; i--)
					push_act(ACT_DC_WORD, {6'd0, dc_mem[CH_W'(i)]}, 6'(i));
				push_act(ACT_LATCH, '0, '0);
				push_act(ACT_BLANK_LO, '0, '0);
				prog_on = 1'b1;
			end
			MODE_TICK: begin
				push_act(ACT_BLANK_HI, '0, '0);
				if (prog_on) begin
					prog_on = 1'b0;
					first   = 1'b1;
					push_act(ACT_PROG_LO, '0, '0);
				end
				if (latch_due) begin
					latch_due = 1'b0;
					push_act(ACT_LATCH, '0, '0);
				end
				if (first)
					push_act(ACT_XCLK, '0, '0);
				push_act(ACT_BLANK_LO, '0, '0);
				if (data_due) begin
					data_due = 1'b0;
					for (int i = CHANNELS - 1; i >= 0; i--)
						push_act(ACT_GS_WORD, gs_mem[CH_W'(i)], 6'(i));
					latch_due = 1'b1;
				end else begin
					latch_due = 1'b0;
				end
			end
			default: ;
		endcase
		// mark the final action of the run
		if (due_actions.size() > n0) begin
			b      = due_actions.pop_back();
			b.last = 1'b1;
			due_actions.push_back(b);
		end
	endfunction

	// Offer one command and hold it until the transfer; tvalid stays high so
	// a following command can go out back to back.
	task automatic send_cmd(logic [2:0] mode, logic [7:0] ch, logic [15:0] val);
		while ($urandom_range(99) < snd_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {val, ch};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		apply_command(mode, ch, val);
	endtask

	// Drop tvalid and wait for every predicted action to come out.
	task automatic drain_actions();
		s_tvalid <= 1'b0;
		while (due_actions.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_reset_contents();
		send_cmd(MODE_TICK, '0, '0);
		send_cmd(MODE_INIT, '0, '0);
		send_cmd(MODE_TICK, '0, '0);
		send_cmd(MODE_UPDATE, '0, '0);
		send_cmd(MODE_TICK, '0, '0);
		send_cmd(MODE_TICK, '0, '0);
		drain_actions();
	endtask

	task automatic test_write_extremes();
		send_cmd(MODE_WR_GS, 8'd0, 16'd0);
		send_cmd(MODE_WR_GS, 8'(CHANNELS - 1), 16'd4095);
		send_cmd(MODE_WR_GS, 8'd1, 16'd4096);
		send_cmd(MODE_WR_GS, 8'd2, 16'hFFFF);
		send_cmd(MODE_WR_GS, 8'(CHANNELS), 16'h0ABC);
		send_cmd(MODE_WR_GS, 8'hFF, 16'h0123);
		send_cmd(MODE_WR_DC, 8'd0, 16'd0);
		send_cmd(MODE_WR_DC, 8'(CHANNELS - 1), 16'd63);
		send_cmd(MODE_WR_DC, 8'd3, 16'd64);
		send_cmd(MODE_WR_DC, 8'd4, 16'hFFFF);
		send_cmd(MODE_WR_DC, 8'hC8, 16'd5);
		// unused modes are dropped
		for (int m = int'(MODE_TICK) + 1; m < 8; m++)
			send_cmd(3'(m), 8'($urandom), 16'($urandom));
		send_cmd(MODE_UPDATE, '0, '0);
		send_cmd(MODE_UPDATE, '0, '0);
		send_cmd(MODE_TICK, '0, '0);
		send_cmd(MODE_INIT, '0, '0);
		send_cmd(MODE_INIT, '0, '0);
		send_cmd(MODE_TICK, '0, '0);
		send_cmd(MODE_TICK, '0, '0);
		drain_actions();
	endtask

	// Stall the receiver while long runs keep arriving, so the input backs up.
	task automatic test_backpressure();
		hold_req++;
		send_cmd(MODE_WR_GS, 8'd5, 16'h0FED);
		send_cmd(MODE_UPDATE, '0, '0);
		send_cmd(MODE_TICK, '0, '0);
		send_cmd(MODE_UPDATE, '0, '0);
		send_cmd(MODE_TICK, '0, '0);
		send_cmd(MODE_INIT, '0, '0);
		send_cmd(MODE_TICK, '0, '0);
		drain_actions();
	endtask

	task automatic send_random_write();
		logic [2:0]  mode;
		logic [7:0]  ch;
		logic [15:0] val;
		mode = ($urandom_range(2) == 0) ? MODE_WR_DC : MODE_WR_GS;
		ch   = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(CHANNELS - 1));
		case ($urandom_range(3))
			0:       val = 16'($urandom);
			1:       val = 16'($urandom_range(GS_MAX));
			2:       val = 16'($urandom_range(DC_MAX + 1));
			default: val = ($urandom_range(1) == 0) ? 16'hFFFF : 16'd0;
		endcase
		send_cmd(mode, ch, val);
	endtask

	// Mostly well-formed frames (writes, update, tick), with noise in between.
	task automatic test_random_frames(int n_items);
		int sent;
		int k;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(9) < 7) begin
				k = $urandom_range(6, 1);
				repeat (k)
					send_random_write();
				sent += k;
				if ($urandom_range(3) != 0) begin
					send_cmd(MODE_UPDATE, 8'($urandom), 16'($urandom));
					sent++;
				end
				send_cmd(MODE_TICK, 8'($urandom), 16'($urandom));
				sent++;
				if ($urandom_range(2) == 0) begin
					send_cmd(MODE_TICK, '0, '0);
					sent++;
				end
			end else begin
				case ($urandom_range(3))
					0: send_cmd(MODE_INIT, 8'($urandom), 16'($urandom));
					1: send_cmd(3'($urandom_range(7, int'(MODE_TICK) + 1)),
						8'($urandom), 16'($urandom));
					2: send_cmd(MODE_UPDATE, 8'($urandom), 16'($urandom));
					default: send_cmd(MODE_TICK, 8'($urandom), 16'($urandom));
				endcase
				sent++;
			end
		end
		drain_actions();
	endtask

	// Receiver: random idling plus an occasional long hold-off on request.
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	// Check every output transfer against the oldest predicted action.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen.action = m_tuser;
			seen.word   = m_tdata[11:0];
			seen.chan   = m_tdata[17:12];
			seen.last   = m_tlast;
			if (due_actions.size() == 0) begin
				errors++;
				$display("%0t unexpected transfer: action %0d word %h chan %0d last %b",
					$time, seen.action, seen.word, seen.chan, seen.last);
			end else begin
				want = due_actions.pop_front();
				if (seen != want || m_tdata[23:18] != '0) begin
					errors++;
					$display("%0t mismatch: expected action %0d word %h chan %0d last %b pad 0",
						$time, want.action, want.word, want.chan, want.last);
					$display("%0t           got      action %0d word %h chan %0d last %b pad %h",
						$time, seen.action, seen.word, seen.chan, seen.last, m_tdata[23:18]);
				end
			end
		end
	end

	// Watchdog on cycles with no transfer on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cnt <= 0;
		else
			quiet_cnt <= quiet_cnt + 1;
		if (quiet_cnt >= WDOG_LIMIT) begin
			$display("%0t watchdog: no transfer for %0d cycles", $time, WDOG_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < CHANNELS; i++) begin
			gs_mem[CH_W'(i)] = '0;
			dc_mem[CH_W'(i)] = DC_MAX;
		end
		data_due  = 1'b0;
		latch_due = 1'b0;
		prog_on   = 1'b0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		snd_idle = 8;
		rcv_idle = 71;
		test_reset_contents();
		test_write_extremes();
		test_backpressure();
		test_random_frames(120);

		snd_idle = 71;
		rcv_idle = 8;
		test_random_frames(120);

		snd_idle = 0;
		rcv_idle = 0;
		test_random_frames(120);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
